// File: rtl/core/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants for the UTF-8 stream decoder with statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8d_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned CP_W       = 31;
  localparam int unsigned CNT_OUT_W  = 16;
  localparam int unsigned WC_W       = 3;
  localparam int unsigned PEND_W     = 3;
  localparam int unsigned RES_DEPTH  = 4;

  localparam int unsigned S_DATA_W   = 8;
  localparam int unsigned S_USER_W   = 1;
  localparam int unsigned M_DATA_W   = 56;
  localparam int unsigned M_USER_W   = 2;

  localparam logic [CP_W-1:0] WIDE4_MIN = CP_W'(32'h0001_0000);
  localparam logic [CP_W-1:0] WIDE2_MIN = CP_W'(32'h0000_0100);

  localparam logic [WC_W-1:0] WC_ONE  = WC_W'(1);
  localparam logic [WC_W-1:0] WC_TWO  = WC_W'(2);
  localparam logic [WC_W-1:0] WC_FOUR = WC_W'(4);

  typedef enum logic [1:0] {
    KIND_CHAR      = 2'd0,
    KIND_SUMMARY   = 2'd1,
    KIND_MALFORMED = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [CP_W-1:0]       code_point;
    logic [CNT_OUT_W-1:0]  char_count;
    logic [WC_W-1:0]       width_class;
    logic                  last;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

endpackage

// File: rtl/core/utf8_stream_decoder_with_stats_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_with_stats_core
// Decodes a legacy UTF-8 byte stream (1 to 6 byte sequences) into code
// points and reports per-string character count and width class.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] byte, tuser[0] byte present, tlast string end
// m_axis    out  tuser[1:0] kind, tdata code/count/width, tlast last result
//
// One input transaction per cycle unless stalled; its results enter the
// queue on the same edge and appear on m_axis the next cycle at the earliest.
// A transaction with a summary after a character yields two results, so the
// output side (one result per cycle unless stalled) sets the rate for those.
// s_axis_tready drops while the 4-entry result queue has fewer than 2 free.
// Reset clears the string state and empties the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder_with_stats_core #(
  parameter int unsigned CountBits = u8d_pkg::COUNT_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [u8d_pkg::S_DATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
  input  logic [u8d_pkg::S_USER_W-1:0]     s_axis_tuser,  // [0] byte_present
  input  logic                             s_axis_tlast,  // string_end
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [30:0] code_point, [46:31] char_count, [49:47] width_class, [55:50] zero
  output logic [u8d_pkg::M_DATA_W-1:0]     m_axis_tdata,
  output logic [u8d_pkg::M_USER_W-1:0]     m_axis_tuser,  // [1:0] result_kind
  output logic                             m_axis_tlast   // last_of_run
);

  import u8d_pkg::*;

  logic       fire;
  logic       room;
  res_pair_t  res;
  result_t    head;

  assign s_axis_tready = room;
  assign fire          = s_axis_tvalid && s_axis_tready;

  u8d_step #(
    .CountBits (CountBits)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .byte_i    (s_axis_tdata[7:0]),
    .present_i (s_axis_tuser[0]),
    .end_i     (s_axis_tlast),
    .res_o     (res)
  );

  u8d_resq u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fire),
    .wr_data_i (res),
    .room_o    (room),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .data_o    (head)
  );

  assign m_axis_tdata = M_DATA_W'({head.width_class, head.char_count, head.code_point});
  assign m_axis_tuser = M_USER_W'(head.kind);
  assign m_axis_tlast = head.last;

endmodule

// File: rtl/core/u8d_step.sv
// ----------------------------------------------------------------------------
// u8d_step
// Per-byte decode step: string state registers and the logic that turns one
// input transaction into zero, one or two results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_step #(
  parameter int unsigned CountBits = u8d_pkg::COUNT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           byte_i,
  input  logic                 present_i,
  input  logic                 end_i,
  output u8d_pkg::res_pair_t   res_o
);

  import u8d_pkg::*;

  logic [PEND_W-1:0]     pend_q, pend_d, pend1;
  logic [CP_W-1:0]       acc_q, acc_d, acc1, acc_sh;
  logic [CountBits-1:0]  cnt_q, cnt_d, cnt1;
  logic [CP_W-1:0]       max_q, max_d, max1;
  logic                  disc_q, disc_d, disc1;

  logic                  chr, mal1, mal2, summ;
  logic [CP_W-1:0]       chr_cp;
  logic [PEND_W-1:0]     pend_dec;
  logic [CountBits+CNT_OUT_W-1:0] cnt_ext;
  logic [WC_W-1:0]       wc;
  result_t               first_r, second_r;
  logic                  has_first, has_second;

  assign acc_sh   = {acc_q[CP_W-7:0], byte_i[5:0]};
  assign pend_dec = pend_q - PEND_W'(1);

  always_comb begin
    chr    = 1'b0;
    mal1   = 1'b0;
    chr_cp = '0;
    pend1  = pend_q;
    acc1   = acc_q;
    if (present_i && !disc_q) begin
      if (pend_q == '0) begin
        if (!byte_i[7]) begin
          chr    = 1'b1;
          chr_cp = CP_W'(byte_i);
        end else if (!byte_i[6]) begin
          mal1 = 1'b1;
        end else if (!byte_i[5]) begin
          acc1 = CP_W'(byte_i[4:0]); pend1 = PEND_W'(1);
        end else if (!byte_i[4]) begin
          acc1 = CP_W'(byte_i[3:0]); pend1 = PEND_W'(2);
        end else if (!byte_i[3]) begin
          acc1 = CP_W'(byte_i[2:0]); pend1 = PEND_W'(3);
        end else if (!byte_i[2]) begin
          acc1 = CP_W'(byte_i[1:0]); pend1 = PEND_W'(4);
        end else if (!byte_i[1]) begin
          acc1 = CP_W'(byte_i[0]);   pend1 = PEND_W'(5);
        end else begin
          mal1 = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        mal1 = 1'b1;
      end else begin
        pend1 = pend_dec;
        acc1  = acc_sh;
        if (pend_dec == '0) begin
          chr    = 1'b1;
          chr_cp = acc_sh;
          acc1   = '0;
        end
      end
    end
    if (mal1) begin
      pend1 = '0;
      acc1  = '0;
    end
  end

  assign disc1 = disc_q | mal1;
  assign cnt1  = (chr && cnt_q != '1) ? cnt_q + CountBits'(1) : cnt_q;
  assign max1  = (chr && chr_cp > max_q) ? chr_cp : max_q;

  assign mal2 = end_i && !disc1 && pend1 != '0;
  assign summ = end_i && !disc1 && pend1 == '0;

  assign cnt_ext = {{CNT_OUT_W{1'b0}}, cnt1};

  always_comb begin
    if (max1 >= WIDE4_MIN)     wc = WC_FOUR;
    else if (max1 > WIDE2_MIN) wc = WC_TWO;
    else                       wc = WC_ONE;
  end

  assign has_first  = chr | mal1;
  assign has_second = mal2 | summ;

  always_comb begin
    first_r             = '0;
    first_r.kind        = chr ? KIND_CHAR : KIND_MALFORMED;
    first_r.code_point  = chr_cp;
    first_r.last        = !has_second;

    second_r             = '0;
    second_r.kind        = summ ? KIND_SUMMARY : KIND_MALFORMED;
    second_r.char_count  = summ ? cnt_ext[CNT_OUT_W-1:0] : '0;
    second_r.width_class = summ ? wc : '0;
    second_r.last        = 1'b1;

    res_o.num = 2'(has_first) + 2'(has_second);
    res_o.r0  = has_first ? first_r : second_r;
    res_o.r1  = second_r;
  end

  always_comb begin
    if (end_i) begin
      pend_d = '0;
      acc_d  = '0;
      cnt_d  = '0;
      max_d  = '0;
      disc_d = 1'b0;
    end else begin
      pend_d = pend1;
      acc_d  = acc1;
      cnt_d  = cnt1;
      max_d  = max1;
      disc_d = disc1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      max_q  <= '0;
      disc_q <= 1'b0;
    end else if (fire_i) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      max_q  <= max_d;
      disc_q <= disc_d;
    end
  end

endmodule

// File: rtl/core/u8d_resq.sv
// ----------------------------------------------------------------------------
// u8d_resq
// Result queue: takes up to two results per cycle, gives one per ready cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_resq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  u8d_pkg::res_pair_t  wr_data_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output u8d_pkg::result_t    data_o
);

  import u8d_pkg::*;

  localparam int unsigned PtrW = $clog2(RES_DEPTH);
  localparam int unsigned CntW = $clog2(RES_DEPTH + 1);

  result_t            mem_q [RES_DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [1:0]         n_wr;
  logic               rd;

  assign n_wr    = wr_i ? wr_data_i.num : 2'd0;
  assign rd      = valid_o && ready_i;
  assign valid_o = cnt_q != '0;
  assign room_o  = cnt_q <= CntW'(RES_DEPTH - 2);
  assign data_o  = mem_q[rd_ptr_q];

  assign wr_ptr_d = wr_ptr_q + PtrW'(n_wr);
  assign rd_ptr_d = rd_ptr_q + PtrW'(rd);
  assign cnt_d    = cnt_q + CntW'(n_wr) - CntW'(rd);

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      mem_q[wr_ptr_q] <= wr_data_i.r0;
    end
    if (n_wr == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= wr_data_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/core/u8d_checker.sv
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8d_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [u8d_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input  logic [u8d_pkg::M_USER_W-1:0]  m_axis_tuser,
  input  logic                          m_axis_tlast
);

  import u8d_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  a_summary_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == M_USER_W'(KIND_SUMMARY)
      || m_axis_tuser == M_USER_W'(KIND_MALFORMED)) |-> m_axis_tlast)
    else $error("summary or malformed result not last of run");

  a_char_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == M_USER_W'(KIND_CHAR) |->
      m_axis_tdata[49:31] == '0)
    else $error("character result carries count or width");

  a_wc_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == M_USER_W'(KIND_SUMMARY) |->
      m_axis_tdata[49:47] == WC_ONE || m_axis_tdata[49:47] == WC_TWO
      || m_axis_tdata[49:47] == WC_FOUR)
    else $error("illegal width class");

  a_mal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == M_USER_W'(KIND_MALFORMED) |->
      m_axis_tdata == '0)
    else $error("malformed result carries payload");

endmodule

bind utf8_stream_decoder_with_stats_core u8d_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: verif/utf8_stream_decoder_with_stats_core_test.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_with_stats_core_test
// Self-checking test of the UTF-8 stream decoder. Byte transactions go in
// through s_axis. A built-in decoder model predicts the code point, malformed
// and summary results, and each m_axis transaction is checked against them in
// order. Coverage comes from directed strings, random strings under several
// idle/stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_stream_decoder_with_stats_core_test;
  import u8d_pkg::*;

  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned PhaseItems    = 170;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [S_USER_W-1:0] s_axis_tuser  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [M_USER_W-1:0] m_axis_tuser;
  logic                m_axis_tlast;

  utf8_stream_decoder_with_stats_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // decoder model state
  logic [PEND_W-1:0]     pend_cont  = '0;
  logic [CP_W-1:0]       acc_cp     = '0;
  logic [CP_W-1:0]       top_cp     = '0;
  logic [COUNT_BITS-1:0] chars_seen = '0;
  logic                  dropping   = 1'b0;

  result_t     decoded_q[$];
  int unsigned err_cnt        = 0;
  int unsigned items_sent     = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned idle_cycles    = 0;
  int unsigned hold_left      = 0;
  logic        hold_tog       = 1'b0;
  logic        hold_seen      = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic result_t take_char(input logic [CP_W-1:0] cp);
    result_t r;
    r = '0;
    r.kind = KIND_CHAR;
    r.code_point = cp;
    if (chars_seen != '1) chars_seen = chars_seen + 1'b1;
    if (cp > top_cp) top_cp = cp;
    return r;
  endfunction

  function automatic result_t take_malformed();
    result_t r;
    r = '0;
    r.kind = KIND_MALFORMED;
    dropping = 1'b1;
    pend_cont = '0;
    acc_cp = '0;
    return r;
  endfunction

  function automatic void predict_decode(input logic [7:0] b, input logic present,
                                         input logic fin);
    result_t rs[$];
    result_t r;
    if (present && !dropping) begin
      if (pend_cont == 0) begin
        if (!b[7]) rs.push_back(take_char(CP_W'(b)));
        else if (!b[6]) rs.push_back(take_malformed());
        else if (!b[5]) begin acc_cp = CP_W'(b[4:0]); pend_cont = 3'd1; end
        else if (!b[4]) begin acc_cp = CP_W'(b[3:0]); pend_cont = 3'd2; end
        else if (!b[3]) begin acc_cp = CP_W'(b[2:0]); pend_cont = 3'd3; end
        else if (!b[2]) begin acc_cp = CP_W'(b[1:0]); pend_cont = 3'd4; end
        else if (!b[1]) begin acc_cp = CP_W'(b[0]);   pend_cont = 3'd5; end
        else rs.push_back(take_malformed());
      end else if (b[7:6] != 2'b10) begin
        rs.push_back(take_malformed());
      end else begin
        acc_cp = {acc_cp[CP_W-7:0], b[5:0]};
        pend_cont = pend_cont - 1'b1;
        if (pend_cont == 0) begin
          rs.push_back(take_char(acc_cp));
          acc_cp = '0;
        end
      end
    end
    if (fin) begin
      if (!dropping) begin
        if (pend_cont != 0) begin
          rs.push_back(take_malformed());
        end else begin
          r = '0;
          r.kind = KIND_SUMMARY;
          r.char_count = CNT_OUT_W'(chars_seen);
          r.width_class = (top_cp >= WIDE4_MIN) ? WC_FOUR :
                          (top_cp > WIDE2_MIN) ? WC_TWO : WC_ONE;
          rs.push_back(r);
        end
      end
      pend_cont = '0;
      acc_cp = '0;
      chars_seen = '0;
      top_cp = '0;
      dropping = 1'b0;
    end
    foreach (rs[i]) begin
      r = rs[i];
      r.last = (i == rs.size() - 1);
      decoded_q.push_back(r);
    end
  endfunction

  // byte idx of the nbytes-long encoding of cp (overlong forms allowed)
  function automatic logic [7:0] code_byte(input int unsigned cp, input int unsigned nbytes,
                                           input int unsigned idx);
    int unsigned shift;
    shift = 6 * (nbytes - 1 - idx);
    if (nbytes == 1) return {1'b0, cp[6:0]};
    if (idx == 0)
      return 8'((32'hFF << (8 - nbytes)) | ((cp >> shift) & ((32'd1 << (7 - nbytes)) - 1)));
    return 8'(32'h80 | ((cp >> shift) & 32'h3F));
  endfunction

  task automatic send_byte_item(input logic [7:0] b, input logic present, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= present;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_decode(b, present, fin);
    if (present || fin) items_sent++;
  endtask

  // sends the first keep bytes; fin rides on the last byte sent
  task automatic send_char(input int unsigned cp, input int unsigned nbytes,
                           input int unsigned keep, input logic fin);
    for (int unsigned i = 0; i < keep; i++)
      send_byte_item(code_byte(cp, nbytes, i), 1'b1, fin && (i == keep - 1));
  endtask

  task automatic send_random_string();
    int unsigned nchars;
    int unsigned roll;
    int unsigned nbytes;
    int unsigned cp;
    logic        fin_rides;
    logic        fin;
    nchars = ($urandom_range(9) == 0) ? 0 : $urandom_range(10, 1);
    fin_rides = (nchars != 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < nchars; i++) begin
      fin = fin_rides && (i == nchars - 1);
      roll = $urandom_range(99);
      if ($urandom_range(19) == 0) send_byte_item(8'($urandom), 1'b0, 1'b0);
      nbytes = (roll >= 4 && roll < 8) ? $urandom_range(6, 2) :
               ($urandom_range(99) < 45) ? 1 : $urandom_range(6, 2);
      cp = $urandom & ((32'd1 << ((nbytes == 1) ? 7 : 5 * nbytes + 1)) - 1);
      if (roll < 4) send_byte_item(8'($urandom), 1'b1, fin);
      else if (roll < 8) send_char(cp, nbytes, $urandom_range(nbytes - 1, 1), fin);
      else send_char(cp, nbytes, nbytes, fin);
    end
    if (!fin_rides) send_byte_item(8'($urandom), $urandom_range(3) == 0, 1'b1);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_directed();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    send_char(32'h100, 2, 2, 1'b1);          // width class 1 at its upper edge
    send_char(32'h101, 2, 2, 1'b1);          // width class 2
    send_char(32'h10000, 4, 4, 1'b1);        // width class 4
    send_char(32'h7FFF_FFFF, 6, 6, 1'b1);    // largest code point
    send_byte_item(8'h00, 1'b1, 1'b0);
    send_byte_item(8'h7F, 1'b1, 1'b0);
    send_byte_item(8'h80, 1'b1, 1'b0);       // bare continuation
    send_byte_item(8'h41, 1'b1, 1'b0);       // dropped
    send_byte_item(8'h00, 1'b0, 1'b1);
    send_byte_item(8'hFE, 1'b1, 1'b1);       // invalid lead, end on same item
    send_byte_item(8'hFF, 1'b1, 1'b0);
    send_byte_item(8'hC3, 1'b1, 1'b0);
    send_byte_item(8'h41, 1'b1, 1'b1);       // missing continuation, but dropped after the 0xFF lead
    send_byte_item(8'hE2, 1'b1, 1'b0);
    send_byte_item(8'h82, 1'b1, 1'b0);
    send_byte_item(8'hFF, 1'b0, 1'b1);       // ends mid-sequence
    send_byte_item(8'hAA, 1'b0, 1'b0);       // no-op item
    send_byte_item(8'h55, 1'b0, 1'b1);       // empty string
    drain_results();
  endtask

  task automatic test_random(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned stop_at;
    src_idle_pct = src_pct;
    sink_stall_pct = snk_pct;
    stop_at = items_sent + PhaseItems;
    while (items_sent < stop_at) send_random_string();
    drain_results();
  endtask

  // output held off while input keeps coming, then sender waits for all results
  task automatic test_receiver_hold();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_tog <= ~hold_tog;
    repeat (6) send_random_string();
    drain_results();
  endtask

  task automatic check_result();
    result_t want;
    if (decoded_q.size() == 0) begin
      $error("unexpected result: kind %0d tdata %0h", m_axis_tuser, m_axis_tdata);
      err_cnt++;
      return;
    end
    want = decoded_q.pop_front();
    if (kind_e'(m_axis_tuser) !== want.kind) begin
      $error("result_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
      err_cnt++;
    end
    if (m_axis_tdata[30:0] !== want.code_point) begin
      $error("code_point: expected %0h, got %0h", want.code_point, m_axis_tdata[30:0]);
      err_cnt++;
    end
    if (m_axis_tdata[46:31] !== want.char_count) begin
      $error("char_count: expected %0d, got %0d", want.char_count, m_axis_tdata[46:31]);
      err_cnt++;
    end
    if (m_axis_tdata[49:47] !== want.width_class) begin
      $error("width_class: expected %0d, got %0d", want.width_class, m_axis_tdata[49:47]);
      err_cnt++;
    end
    if (m_axis_tlast !== want.last) begin
      $error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(0, 0);
    test_random(80, 0);
    test_random(0, 80);
    test_random(25, 25);
    test_receiver_hold();
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: utf8_stream_decoder_with_stats_core.f
rtl/core/u8d_pkg.sv
rtl/core/u8d_step.sv
rtl/core/u8d_resq.sv
rtl/core/utf8_stream_decoder_with_stats_core.sv
rtl/core/u8d_checker.sv
verif/utf8_stream_decoder_with_stats_core_test.sv
